[hdl/bae_pkg.sv]
// shared types and constants of the ack estimator
package bae_pkg;

  localparam int WINDOW_SIZE = 8;
  localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

  localparam logic [31:0] RTT_INIT     = 32'h7fff_ffff;
  localparam logic [31:0] RATE_SAT     = 32'hffff_ffff;
  localparam logic [15:0] GAIN_STARTUP = 16'd739;
  localparam logic [15:0] GAIN_DRAIN   = 16'd89;
  localparam logic [1:0]  PLATEAU_LIMIT = 2'd3;
  localparam logic [7:0]  HEADER_RESET = 8'd24;

  typedef enum logic [1:0] {
    MODE_STARTUP  = 2'd0,
    MODE_DRAIN    = 2'd1,
    MODE_PROBE_BW = 2'd2,
    MODE_PROBE_RTT = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MODE,
    ST_RTT_SCAN,
    ST_DIFF,
    ST_DIV,
    ST_RATE,
    ST_BW_SCAN,
    ST_DONE
  } state_t;

  // probe_bw pacing gain cycle, Q8.8
  function automatic logic [15:0] cycle_gain(input logic [2:0] idx);
    case (idx)
      3'd0:    cycle_gain = 16'd320;
      3'd1:    cycle_gain = 16'd192;
      default: cycle_gain = 16'd256;
    endcase
  endfunction

endpackage

[hdl/bbr_ack_estimator.sv]
// per-ack bandwidth and rtt estimator with mode machine
//
// Input words carry one acknowledgement (times, delivered stamp, length,
// bytes in flight); each accepted word yields exactly one output word with
// the mode, gains, windowed min rtt, windowed max bandwidth and this ack's
// delivery rate. A word is accepted when in_valid is high and in_stall low.
// The block works on one ack at a time and holds in_stall high meanwhile.
// Between accept and result come one multiply, a window scan of one entry
// per cycle for min rtt and for max bandwidth, and a 32-step restoring
// divider for the delivery rate, which sets the pace. The next word is
// accepted in the idle cycle after the result loads. The divide is skipped
// when the rate saturates, the bandwidth scan when the rate does not raise
// the max.
// The result sits in an output register until out_stall is low; the next
// word is accepted meanwhile, and the block waits to finish it only if the
// previous result is still not taken.
// header_bytes is written via cfg_write_enable/cfg_write_data; the user must
// write it only while idle, which the block itself does not enforce.
// A synchronous reset restores the startup mode, the windows and the
// header size of 24 bytes.
module bbr_ack_estimator import bae_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [7:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_time,
  input  logic [31:0] sent_time,
  input  logic [47:0] sent_delivered,
  input  logic [15:0] segment_length,
  input  logic [31:0] inflight_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  mode,
  output logic [15:0] pace_factor,
  output logic [15:0] window_factor,
  output logic [31:0] min_rtt,
  output logic [31:0] max_bandwidth,
  output logic [31:0] delivery_rate
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SIZE - 1);

  state_t state, state_next;
  logic   in_accept, out_accept;

  logic [7:0]  header_bytes;
  logic [31:0] now_q, sent_q, inflight_q;
  logic [47:0] sent_del_q;
  logic [15:0] len_q;

  mode_t       bbr_mode;
  logic [2:0]  gain_idx;
  logic [1:0]  plateau;
  logic [47:0] delivered_total;
  logic [31:0] rtt_win [WINDOW_SIZE];
  logic [31:0] bw_win [WINDOW_SIZE];
  logic [31:0] cur_min_rtt, cur_max_bw, prev_max_bw;
  logic [15:0] pacing_reg, cwnd_reg;

  logic [63:0] prod;
  logic [31:0] rtt, rate, acc;
  logic [47:0] diff;
  logic [IDX_W-1:0] k;

  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;

  logic [34:0] prev_x5, cur_x4;
  logic        plateau_hit;
  logic [1:0]  plateau_inc;
  logic [15:0] payload;
  logic        sat;
  logic        out_free;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign in_stall   = (state != ST_IDLE);
  assign out_free   = !out_valid || out_accept;

  // mode machine, payload and rate saturation helpers
  always_comb begin
    prev_x5     = {prev_max_bw, 2'b00} + {3'b000, prev_max_bw};
    cur_x4      = {1'b0, cur_max_bw, 2'b00};
    plateau_hit = (prev_x5 > cur_x4);
    plateau_inc = plateau_hit ? plateau + 2'd1 : plateau;
    payload     = (len_q >= {8'd0, header_bytes}) ? len_q - {8'd0, header_bytes} : 16'd0;
    sat         = (rtt == 32'd0) || (diff[47:16] >= rtt);
  end

  // next state
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ST_IDLE:     if (in_accept) state_next = ST_MUL;
      ST_MUL:      state_next = ST_MODE;
      ST_MODE:     state_next = ST_RTT_SCAN;
      ST_RTT_SCAN: if (k == LAST_IDX) state_next = ST_DIFF;
      ST_DIFF: begin
        if (sat) begin
          state_next = ST_RATE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV:      if (div_done) state_next = ST_RATE;
      ST_RATE:     state_next = (rate > cur_max_bw) ? ST_BW_SCAN : ST_DONE;
      ST_BW_SCAN:  if (k == LAST_IDX) state_next = ST_DONE;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state and estimates
  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes    <= HEADER_RESET;
      bbr_mode        <= MODE_STARTUP;
      gain_idx        <= '0;
      plateau         <= '0;
      delivered_total <= '0;
      cur_min_rtt     <= RTT_INIT;
      cur_max_bw      <= '0;
      prev_max_bw     <= '0;
      pacing_reg      <= GAIN_STARTUP;
      cwnd_reg        <= '0;
      out_valid       <= 1'b0;
      k               <= '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        rtt_win[i] <= RTT_INIT;
        bw_win[i]  <= '0;
      end
    end else begin
      if (cfg_write_enable) header_bytes <= cfg_write_data;
      out_valid <= ((state == ST_DONE) && out_free) || (out_valid && !out_accept);
      case (state)
        // run the mode machine on the previous estimates, add the payload and shift the rtt window
        ST_MODE: begin
          case (bbr_mode)
            MODE_STARTUP: begin
              cwnd_reg <= GAIN_STARTUP;
              if (plateau_inc == PLATEAU_LIMIT) begin
                bbr_mode   <= MODE_DRAIN;
                plateau    <= '0;
                pacing_reg <= GAIN_DRAIN;
              end else begin
                plateau    <= plateau_inc;
                pacing_reg <= GAIN_STARTUP;
              end
            end
            MODE_DRAIN: begin
              if ({inflight_q, 16'd0} <= prod) begin
                bbr_mode   <= MODE_PROBE_BW;
                pacing_reg <= cycle_gain(3'd0);
                gain_idx   <= 3'd1;
              end else begin
                pacing_reg <= GAIN_DRAIN;
              end
            end
            MODE_PROBE_BW: begin
              pacing_reg <= cycle_gain(gain_idx);
              gain_idx   <= gain_idx + 3'd1;
            end
            default: begin
            end
          endcase
          delivered_total <= delivered_total + {32'd0, payload};
          for (int i = 0; i < WINDOW_SIZE - 1; i++) rtt_win[i] <= rtt_win[i + 1];
          rtt_win[WINDOW_SIZE - 1] <= rtt;
          k <= '0;
        end
        // min over the rtt window, one entry a cycle
        ST_RTT_SCAN: begin
          k <= (k == LAST_IDX) ? '0 : k + 1'b1;
          if (k == LAST_IDX) cur_min_rtt <= (rtt_win[k] < acc) ? rtt_win[k] : acc;
        end
        ST_RATE: begin
          prev_max_bw <= cur_max_bw;
          if (rate > cur_max_bw) begin
            for (int i = 0; i < WINDOW_SIZE - 1; i++) bw_win[i] <= bw_win[i + 1];
            bw_win[WINDOW_SIZE - 1] <= rate;
          end
          k <= '0;
        end
        // max over the bandwidth window
        ST_BW_SCAN: begin
          k <= (k == LAST_IDX) ? '0 : k + 1'b1;
          if (k == LAST_IDX) cur_max_bw <= (bw_win[k] > acc) ? bw_win[k] : acc;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          now_q      <= now_time;
          sent_q     <= sent_time;
          sent_del_q <= sent_delivered;
          len_q      <= segment_length;
          inflight_q <= inflight_bytes;
        end
      end
      ST_MUL: begin
        prod <= 64'(cur_max_bw) * 64'(cur_min_rtt);
        rtt  <= now_q - sent_q;
      end
      ST_MODE: acc <= 32'hffff_ffff;
      ST_RTT_SCAN: if (rtt_win[k] < acc) acc <= rtt_win[k];
      ST_DIFF: begin
        if (sat) rate <= RATE_SAT;
      end
      ST_DIV: if (div_done) rate <= div_q;
      ST_RATE: acc <= '0;
      ST_BW_SCAN: if (bw_win[k] > acc) acc <= bw_win[k];
      ST_DONE: begin
        if (out_free) begin
          mode          <= bbr_mode;
          pace_factor   <= pacing_reg;
          window_factor <= cwnd_reg;
          min_rtt       <= cur_min_rtt;
          max_bandwidth <= cur_max_bw;
          delivery_rate <= rate;
        end
      end
      default: begin
      end
    endcase
    // delivered difference, ready by the divide step
    if (state == ST_RTT_SCAN) diff <= delivered_total - sent_del_q;
  end

  // rate divider: (diff << 16) / rtt, high part known below the divisor
  bae_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend_hi (diff[47:16]),
    .dividend_lo ({diff[15:0], 16'd0}),
    .divisor     (rtt),
    .done        (div_done),
    .quotient    (div_q)
  );

endmodule

[hdl/bae_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
module bae_div import bae_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend_hi,
  input  logic [31:0] dividend_lo,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  count;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [31:0] shreg;
  logic [32:0] trial;
  logic        qbit;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, shreg[31]};
    qbit  = (trial >= {1'b0, dvs});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= dividend_hi;
      shreg <= dividend_lo;
      dvs   <= divisor;
    end else if (busy) begin
      rem   <= qbit ? 32'(trial - {1'b0, dvs}) : trial[31:0];
      shreg <= {shreg[30:0], qbit};
    end
  end

  assign quotient = shreg;

endmodule

[hdl/bae_checker.sv]
// port-level checks for the ack estimator, bound to the top level
module bae_checker import bae_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  mode,
  input logic [31:0] delivery_rate
);

  // a word in progress keeps the input side stalled
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(delivery_rate))
    else $error("stalled result dropped or changed");

  // probe_rtt is never entered
  a_no_probe_rtt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mode != MODE_PROBE_RTT)
    else $error("probe_rtt mode reported");

endmodule

bind bbr_ack_estimator bae_checker u_bae_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .mode          (mode),
  .delivery_rate (delivery_rate)
);

[test/bae_ack_checker.sv]
// checker: predicts every ack estimate and compares the output words
module bae_ack_checker import bae_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [7:0]  cfg_write_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] now_time,
  input  logic [31:0] sent_time,
  input  logic [47:0] sent_delivered,
  input  logic [15:0] segment_length,
  input  logic [31:0] inflight_bytes,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] pace_factor,
  input  logic [15:0] window_factor,
  input  logic [31:0] min_rtt,
  input  logic [31:0] max_bandwidth,
  input  logic [31:0] delivery_rate,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] pacing;
    logic [15:0] cwnd;
    logic [31:0] min_rtt;
    logic [31:0] max_bw;
    logic [31:0] rate;
  } estimate_t;

  estimate_t   estimate_q[$];

  // shadow of the estimator state
  logic [7:0]  hdr_len;
  mode_t       cur_mode;
  logic [2:0]  gain_idx;
  logic [1:0]  plateau;
  logic [47:0] delivered;
  logic [31:0] rtt_hist[WINDOW_SIZE];
  logic [31:0] bw_hist[WINDOW_SIZE];
  logic [31:0] rtt_min;
  logic [31:0] bw_max;
  logic [31:0] bw_prev;
  logic [15:0] pace_gain;
  logic [15:0] win_gain;

  function automatic logic [15:0] probe_gain(input logic [2:0] idx);
    if (idx == 3'd0) return 16'd320;
    if (idx == 3'd1) return 16'd192;
    return 16'd256;
  endfunction

  task automatic reset_shadow();
    hdr_len   = HEADER_RESET;
    cur_mode  = MODE_STARTUP;
    gain_idx  = 3'd0;
    plateau   = 2'd0;
    delivered = 48'd0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      rtt_hist[i] = RTT_INIT;
      bw_hist[i]  = 32'd0;
    end
    rtt_min   = RTT_INIT;
    bw_max    = 32'd0;
    bw_prev   = 32'd0;
    pace_gain = GAIN_STARTUP;
    win_gain  = 16'd0;
  endtask

  task automatic predict_ack(input logic [31:0] now_t, input logic [31:0] sent_t,
                             input logic [47:0] sent_del, input logic [15:0] len,
                             input logic [31:0] inflight);
    logic [31:0] rtt;
    logic [31:0] mn;
    logic [31:0] mx;
    logic [31:0] rate;
    logic [31:0] payload;
    logic [47:0] diff;
    logic [63:0] quo;
    estimate_t   e;
    // mode machine on the estimates of the previous ack
    case (cur_mode)
      MODE_STARTUP: begin
        pace_gain = GAIN_STARTUP;
        win_gain  = GAIN_STARTUP;
        if (64'(bw_prev) * 64'd5 > 64'(bw_max) * 64'd4) plateau = plateau + 2'd1;
        if (plateau == PLATEAU_LIMIT) begin
          cur_mode  = MODE_DRAIN;
          plateau   = 2'd0;
          pace_gain = GAIN_DRAIN;
        end
      end
      MODE_DRAIN: begin
        pace_gain = GAIN_DRAIN;
        if ({inflight, 16'd0} <= 64'(bw_max) * 64'(rtt_min)) begin
          cur_mode  = MODE_PROBE_BW;
          pace_gain = probe_gain(3'd0);
          gain_idx  = 3'd1;
        end
      end
      MODE_PROBE_BW: begin
        pace_gain = probe_gain(gain_idx);
        gain_idx  = gain_idx + 3'd1;
      end
      default: ;
    endcase
    // sliding min rtt
    rtt = now_t - sent_t;
    mn  = rtt;
    for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
      rtt_hist[i] = rtt_hist[i + 1];
      if (rtt_hist[i] < mn) mn = rtt_hist[i];
    end
    rtt_hist[WINDOW_SIZE - 1] = rtt;
    rtt_min = mn;
    // delivered bytes and rate
    payload   = (len >= 16'(hdr_len)) ? 32'(len - 16'(hdr_len)) : 32'd0;
    delivered = delivered + 48'(payload);
    diff      = delivered - sent_del;
    if (rtt == 32'd0) begin
      rate = RATE_SAT;
    end else begin
      quo  = {diff, 16'd0} / 64'(rtt);
      rate = (quo > 64'hffff_ffff) ? RATE_SAT : quo[31:0];
    end
    // sliding max bandwidth, entered only on a new max
    bw_prev = bw_max;
    if (rate > bw_max) begin
      mx = rate;
      for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
        bw_hist[i] = bw_hist[i + 1];
        if (bw_hist[i] > mx) mx = bw_hist[i];
      end
      bw_hist[WINDOW_SIZE - 1] = rate;
      bw_max = mx;
    end
    e.mode    = cur_mode;
    e.pacing  = pace_gain;
    e.cwnd    = win_gain;
    e.min_rtt = rtt_min;
    e.max_bw  = bw_max;
    e.rate    = rate;
    estimate_q.push_back(e);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    estimate_t e;
    if (rst) begin
      reset_shadow();
      estimate_q.delete();
    end else begin
      if (cfg_write_enable) hdr_len = cfg_write_data;
      if (in_valid && !in_stall)
        predict_ack(now_time, sent_time, sent_delivered, segment_length, inflight_bytes);
      if (out_valid && !out_stall) begin
        if (estimate_q.size() == 0) begin
          $display("%0t: output word with no estimate waiting", $time);
          errors++;
        end else begin
          e = estimate_q.pop_front();
          check_field("mode", 32'(e.mode), 32'(mode));
          check_field("pace_factor", 32'(e.pacing), 32'(pace_factor));
          check_field("window_factor", 32'(e.cwnd), 32'(window_factor));
          check_field("min_rtt", e.min_rtt, min_rtt);
          check_field("max_bandwidth", e.max_bw, max_bandwidth);
          check_field("delivery_rate", e.rate, delivery_rate);
        end
      end
    end
    pending = estimate_q.size();
  end

endmodule

[test/tb_bbr_ack_estimator.sv]
// testbench top: ack stimulus, register writes, watchdog and verdict
module tb_bbr_ack_estimator;
  import bae_pkg::*;

  localparam int WATCH_LIMIT = 20000;
  localparam int SETTLE      = 80;

  logic        clk;
  logic        rst;
  logic        cfg_write_enable;
  logic [7:0]  cfg_write_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] now_time;
  logic [31:0] sent_time;
  logic [47:0] sent_delivered;
  logic [15:0] segment_length;
  logic [31:0] inflight_bytes;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  mode;
  logic [15:0] pace_factor;
  logic [15:0] window_factor;
  logic [31:0] min_rtt;
  logic [31:0] max_bandwidth;
  logic [31:0] delivery_rate;
  int          errors;
  int          pending;

  logic        quiet;
  logic [7:0]  hdr_len;
  logic [47:0] delivered_sum;
  int          acks_sent;
  int          words_taken;
  int          idle_cycles;
  int          stall_left;

  bbr_ack_estimator u_top (.*);

  bae_ack_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("%0t: no handshake progress, giving up", $time);
        $display("end of test: mismatches");
        $finish;
      end
    end
    if (out_valid && !out_stall) words_taken <= words_taken + 1;
  end

  task automatic send_ack(input logic [31:0] now_t, input logic [31:0] sent_t,
                          input logic [47:0] sent_del, input logic [15:0] len,
                          input logic [31:0] inflight);
    int gap;
    gap = (quiet || $urandom_range(2) != 0) ? 0 : $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    now_time       <= now_t;
    sent_time      <= sent_t;
    sent_delivered <= sent_del;
    segment_length <= len;
    inflight_bytes <= inflight;
    delivered_sum  = delivered_sum + ((len >= 16'(hdr_len)) ? 48'(len - 16'(hdr_len)) : 48'd0);
    do @(posedge clk); while (in_stall);
    acks_sent++;
  endtask

  // mostly sound ack: plausible rtt, delivered stamp close behind the total
  task automatic send_plausible();
    logic [31:0] now_t;
    logic [31:0] rtt;
    logic [15:0] len;
    logic [47:0] payload;
    logic [47:0] sdel;
    logic [31:0] inflight;
    now_t = $urandom();
    case ($urandom_range(9))
      0:       rtt = 32'd0;
      1:       rtt = $urandom();
      default: rtt = $urandom_range(1, 200000);
    endcase
    len = ($urandom_range(4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1600));
    payload = (len >= 16'(hdr_len)) ? 48'(len - 16'(hdr_len)) : 48'd0;
    if ($urandom_range(4) == 0) sdel = {16'($urandom()), 32'($urandom())};
    else sdel = delivered_sum + payload - 48'($urandom_range(0, 200000));
    inflight = ($urandom_range(3) == 0) ? 32'($urandom()) : 32'($urandom_range(0, 3000));
    send_ack(now_t, now_t - rtt, sdel, len, inflight);
  endtask

  // header size write while idle
  task automatic write_header(input logic [7:0] value);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    hdr_len = value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  initial begin
    rst              <= 1'b1;
    quiet            <= 1'b0;
    cfg_write_enable <= 1'b0;
    cfg_write_data   <= 8'd0;
    in_valid         <= 1'b0;
    now_time         <= 32'd0;
    sent_time        <= 32'd0;
    sent_delivered   <= 48'd0;
    segment_length   <= 16'd0;
    inflight_bytes   <= 32'd0;
    hdr_len       = HEADER_RESET;
    delivered_sum = 48'd0;
    acks_sent     = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: startup growth, plateau into drain, drain exit
    send_ack(32'd1000, 32'd900, 48'd0, 16'd1524, 32'hffff_ffff);
    send_ack(32'd2000, 32'd1000, 48'd0, 16'd65535, 32'hffff_ffff);
    send_ack(32'd5, 32'hffff_fff0, 48'hffff_ffff_ffff, 16'd10, 32'hffff_ffff);
    send_ack(32'd7777, 32'd7777, 48'd0, 16'd24, 32'hffff_ffff);
    send_ack(32'hffff_ffff, 32'd0, 48'd0, 16'd0, 32'hffff_ffff);
    send_ack(32'd100, 32'd99, 48'd0, 16'd65535, 32'hffff_ffff);
    send_ack(32'd100, 32'd50, delivered_sum, 16'd100, 32'hffff_ffff);
    send_ack(32'd300, 32'd200, 48'd0, 16'd500, 32'd0);
    send_ack(32'h8000_0000, 32'h7fff_ffff, 48'h0000_0000_0001, 16'd23, 32'h0001_0000);
    for (int i = 0; i < 10; i++) send_plausible();

    // register extremes with short runs in between
    write_header(8'd0);
    send_ack(32'd50, 32'd10, 48'd0, 16'd0, 32'd5);
    send_ack(32'd60, 32'd10, delivered_sum, 16'd65535, 32'd5);
    for (int i = 0; i < 100; i++) send_plausible();
    write_header(8'd255);
    send_ack(32'd70, 32'd10, 48'd0, 16'd254, 32'd5);
    send_ack(32'd80, 32'd10, 48'd0, 16'd255, 32'd5);
    for (int i = 0; i < 300; i++) send_plausible();

    // random phases, each with a fresh header size
    for (int p = 0; p < 6; p++) begin
      write_header(8'($urandom()));
      for (int i = 0; i < 200; i++) send_plausible();
    end
    write_header(HEADER_RESET);
    for (int i = 0; i < 200; i++) send_plausible();

    // closing stretch with no idling on either side
    quiet <= 1'b1;
    for (int i = 0; i < 150; i++) send_plausible();
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d acks and %0d output words across several header sizes",
             acks_sent, words_taken);
    $display("mode machine run from startup through drain into the probe_bw gain cycle");
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/bae_pkg.sv
hdl/bae_div.sv
hdl/bbr_ack_estimator.sv
hdl/bae_checker.sv
test/bae_ack_checker.sv
test/tb_bbr_ack_estimator.sv
